[design/bsp_pkg.sv]
// Shared types and constants for the banked stack pointer register block.
package bsp_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned KindW  = 4;
  localparam int unsigned CfgIdxW = 2;

  // Input tuser layout: kind in the low bits, bank above it.
  localparam int unsigned InUserW = KindW + 1;

  // Output tdata layout, lowest bit first.
  localparam int unsigned OutRdLsb    = 0;
  localparam int unsigned OutSpLsb    = OutRdLsb + DataW;
  localparam int unsigned OutPrivBit  = OutSpLsb + DataW;
  localparam int unsigned OutHandBit  = OutPrivBit + 1;
  localparam int unsigned OutNsBit    = OutHandBit + 1;
  localparam int unsigned OutLowLsb   = OutNsBit + 1;
  localparam int unsigned OutValidBit = OutLowLsb + DataW;
  localparam int unsigned OutUsedW    = OutValidBit + 1;
  localparam int unsigned OutDataW    = ((OutUsedW + 7) / 8) * 8;

  // CONTROL bit positions
  localparam int unsigned NprivBit = 0;
  localparam int unsigned SpselBit = 1;

  typedef enum logic [KindW-1:0] {
    KIND_RD_ACT_SP  = 4'd0,
    KIND_WR_ACT_SP  = 4'd1,
    KIND_RD_ACT_LIM = 4'd2,
    KIND_RD_MSP     = 4'd3,
    KIND_WR_MSP     = 4'd4,
    KIND_RD_PSP     = 4'd5,
    KIND_WR_PSP     = 4'd6,
    KIND_RD_CTRL    = 4'd7,
    KIND_WR_CTRL    = 4'd8,
    KIND_RD_VTOR    = 4'd9,
    KIND_WR_VTOR    = 4'd10,
    KIND_SET_MODE   = 4'd11,
    KIND_SET_SEC    = 4'd12,
    KIND_SET_UNPRIV = 4'd13,
    KIND_NOTE_TOP   = 4'd14,
    KIND_STATUS     = 4'd15
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAIN_LIM_NS = 2'd0,
    CFG_MAIN_LIM_S  = 2'd1,
    CFG_PROC_LIM_NS = 2'd2,
    CFG_PROC_LIM_S  = 2'd3
  } cfg_idx_e;

  // Banked state, one copy per security bank.
  typedef struct packed {
    logic [DataW-1:0] msp;
    logic [DataW-1:0] psp;
    logic [DataW-1:0] ctrl;
    logic [DataW-1:0] vtor;
    logic             unpriv;
    logic [DataW-1:0] low_mark;
    logic             top_known;
  } bank_t;

endpackage

[design/banked_stack_pointer_regs.sv]
// Banked stack pointer and CONTROL register block: top level.
// One access item per cycle is accepted, back to back, while the output side
// is not stalled. An item is captured in an input register, executed against
// the banked state by a single level of muxing and one 32-bit compare
// (low-water mark) once the output register can take it, and its result is
// held in the output register until taken. The result register parts the two
// sides: while a result waits, the input register still takes one item. A
// configuration write is seen by every item executed after its write edge.
module banked_stack_pointer_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bsp_pkg::DataW-1:0]     s_axis_tdata,   // value[31:0]
  input  logic [bsp_pkg::InUserW-1:0]   s_axis_tuser,   // kind[3:0], bank[4]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // read_data[31:0], sp_mirror[63:32], privileged[64], handler_mode[65],
  // nonsecure_now[66], stack_low_mark[98:67], low_mark_valid[99], zero[103:100]
  output logic [bsp_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [bsp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bsp_pkg::DataW-1:0]     cfg_wdata_i
);
  import bsp_pkg::*;

  function automatic bank_t record_top(bank_t x, logic [DataW-1:0] v);
    bank_t r;
    r = x;
    if (!x.top_known && (v != '0)) begin
      r.low_mark  = v;
      r.top_known = 1'b1;
    end
    return r;
  endfunction

  function automatic bank_t lower_mark(bank_t x, logic [DataW-1:0] v);
    bank_t r;
    r = x;
    if (x.top_known && (v < x.low_mark)) begin
      r.low_mark = v;
    end
    return r;
  endfunction

  // limits
  logic [DataW-1:0] main_lim_ns_q, main_lim_s_q, proc_lim_ns_q, proc_lim_s_q;

  // state
  bank_t            bank_q [2];   // 0 secure, 1 non-secure
  bank_t            bank_d [2];
  logic             hand_q, hand_d;
  logic             ns_q, ns_d;
  logic [DataW-1:0] r13_q, r13_d;

  // input register
  logic             in_vld_q;
  kind_e            kind_q;
  logic             bank_sel_q;
  logic [DataW-1:0] value_q;

  // output register
  logic                 out_vld_q;
  logic [OutDataW-1:0]  out_q, out_d;

  logic             advance;
  logic             cb;
  logic             psp_act;
  logic [DataW-1:0] rd;
  logic [DataW-1:0] wval;
  bank_t            tmp;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  always_comb begin
    cb      = ns_q;
    psp_act = !hand_q && bank_q[cb].ctrl[SpselBit];
    bank_d  = bank_q;
    hand_d  = hand_q;
    ns_d    = ns_q;
    r13_d   = r13_q;
    rd      = '0;
    wval    = value_q;
    tmp     = bank_q[bank_sel_q];
    case (kind_q)
      KIND_RD_ACT_SP: begin
        rd = psp_act ? bank_q[cb].psp : bank_q[cb].msp;
      end
      KIND_WR_ACT_SP: begin
        if (psp_act) begin
          bank_d[cb].psp = value_q;
        end else begin
          tmp        = bank_q[cb];
          tmp.msp    = value_q;
          tmp        = lower_mark(record_top(tmp, value_q), value_q);
          bank_d[cb] = tmp;
        end
        r13_d = value_q;
      end
      KIND_RD_ACT_LIM: begin
        if (psp_act) begin
          rd = cb ? proc_lim_ns_q : proc_lim_s_q;
        end else begin
          rd = cb ? main_lim_ns_q : main_lim_s_q;
        end
      end
      KIND_RD_MSP: rd = bank_q[bank_sel_q].msp;
      KIND_WR_MSP: begin
        tmp.msp = value_q;
        if (bank_sel_q == cb && !psp_act) begin
          r13_d = value_q;
        end
        // only the secure bank records its top on an MSP write
        if (!bank_sel_q) begin
          tmp = record_top(tmp, value_q);
        end
        bank_d[bank_sel_q] = lower_mark(tmp, value_q);
      end
      KIND_RD_PSP: rd = bank_q[bank_sel_q].psp;
      KIND_WR_PSP: begin
        bank_d[bank_sel_q].psp = value_q;
        if (bank_sel_q == cb && psp_act) begin
          r13_d = value_q;
        end
      end
      KIND_RD_CTRL: rd = bank_q[bank_sel_q].ctrl;
      KIND_WR_CTRL: begin
        // unprivileged thread code cannot change its own CONTROL
        if (bank_sel_q == cb && !hand_q && tmp.ctrl[NprivBit]) begin
          wval = tmp.ctrl;
        end
        bank_d[bank_sel_q].ctrl   = wval;
        bank_d[bank_sel_q].unpriv = wval[NprivBit];
        if (bank_sel_q == cb) begin
          r13_d = (!hand_q && wval[SpselBit]) ? tmp.psp : tmp.msp;
        end
      end
      KIND_RD_VTOR: rd = bank_q[bank_sel_q].vtor;
      KIND_WR_VTOR: bank_d[bank_sel_q].vtor = value_q;
      KIND_SET_MODE: hand_d = value_q[0];
      KIND_SET_SEC: ns_d = bank_sel_q;
      KIND_SET_UNPRIV: begin
        bank_d[cb].unpriv         = value_q[0];
        bank_d[cb].ctrl[NprivBit] = value_q[0];
      end
      KIND_NOTE_TOP: bank_d[bank_sel_q] = record_top(tmp, tmp.msp);
      default: ;
    endcase

    out_d = '0;
    out_d[OutRdLsb +: DataW]  = rd;
    out_d[OutSpLsb +: DataW]  = r13_d;
    out_d[OutPrivBit]         = hand_d || !bank_d[ns_d].unpriv;
    out_d[OutHandBit]         = hand_d;
    out_d[OutNsBit]           = ns_d;
    out_d[OutLowLsb +: DataW] = bank_d[bank_sel_q].low_mark;
    out_d[OutValidBit]        = bank_d[bank_sel_q].top_known;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_lim_ns_q <= '0;
      main_lim_s_q  <= '0;
      proc_lim_ns_q <= '0;
      proc_lim_s_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAIN_LIM_NS: main_lim_ns_q <= cfg_wdata_i;
        CFG_MAIN_LIM_S:  main_lim_s_q  <= cfg_wdata_i;
        CFG_PROC_LIM_NS: proc_lim_ns_q <= cfg_wdata_i;
        CFG_PROC_LIM_S:  proc_lim_s_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q[0] <= '0;
      bank_q[1] <= '0;
      hand_q    <= 1'b0;
      ns_q      <= 1'b0;
      r13_q     <= '0;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        bank_q <= bank_d;
        hand_q <= hand_d;
        ns_q   <= ns_d;
        r13_q  <= r13_d;
      end
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      kind_q     <= kind_e'(s_axis_tuser[KindW-1:0]);
      bank_sel_q <= s_axis_tuser[KindW];
      value_q    <= s_axis_tdata;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

endmodule

[design/bsp_checker.sv]
// Port-level checker for the banked stack pointer block, with its bind.
module bsp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [bsp_pkg::OutDataW-1:0]  m_axis_tdata
);
  import bsp_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // the output register frees the input side whenever it is not stalled
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled although result side can move");

  // handler mode is always privileged
  a_handler_priv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[OutHandBit] |-> m_axis_tdata[OutPrivBit])
    else $error("handler mode reported unprivileged");

  // the low mark only moves once the bank's top is recorded
  a_low_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[OutValidBit] |-> m_axis_tdata[OutLowLsb +: DataW] == '0)
    else $error("low mark set before top recorded");

endmodule

bind banked_stack_pointer_regs bsp_checker u_bsp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/tb.sv]
// Self-checking testbench for the banked stack pointer and CONTROL register block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bsp_pkg::*;

  localparam int WATCHDOG = 2000;
  localparam int RAND_PER_PHASE = 450;
  localparam int NDIR = 26;

  typedef struct packed {
    logic [DataW-1:0] rd;
    logic [DataW-1:0] sp;
    logic             priv;
    logic             hand;
    logic             ns;
    logic [DataW-1:0] low;
    logic             valid;
  } sp_result_t;

  typedef struct packed {
    kind_e            kind;
    logic             bank;
    logic [DataW-1:0] value;
    logic             fixed;   // use the typed-in result instead of the predictor's
    sp_result_t       want;
  } access_t;

  localparam sp_result_t RES_IDLE = '{rd: '0, sp: '0, priv: 1'b1, hand: 1'b0, ns: 1'b0,
                                      low: '0, valid: 1'b0};
  localparam sp_result_t RES_LIM = '{rd: 32'hFFFF_FFFF, sp: '0, priv: 1'b1, hand: 1'b0,
                                     ns: 1'b0, low: '0, valid: 1'b0};
  localparam sp_result_t RES_TOP = '{rd: '0, sp: 32'hFFFF_FFFF, priv: 1'b1, hand: 1'b0,
                                     ns: 1'b0, low: 32'hFFFF_FFFF, valid: 1'b1};

  localparam access_t DIR_TAB [NDIR] = '{
    '{KIND_STATUS,     1'b0, 32'h0000_0000, 1'b1, RES_IDLE},
    '{KIND_RD_ACT_LIM, 1'b0, 32'h0000_0000, 1'b1, RES_LIM},
    '{KIND_WR_MSP,     1'b0, 32'h0000_0000, 1'b1, RES_IDLE},  // zero never records the top
    '{KIND_WR_MSP,     1'b0, 32'hFFFF_FFFF, 1'b1, RES_TOP},
    '{KIND_WR_MSP,     1'b0, 32'h1000_0000, 1'b0, '0},        // lowers the secure mark
    '{KIND_WR_MSP,     1'b1, 32'h2000_0000, 1'b0, '0},        // no top for non-secure
    '{KIND_NOTE_TOP,   1'b1, 32'h0000_0000, 1'b0, '0},
    '{KIND_WR_MSP,     1'b1, 32'h1FFF_FF00, 1'b0, '0},
    '{KIND_WR_PSP,     1'b0, 32'h3000_0000, 1'b0, '0},        // PSP not active yet
    '{KIND_WR_CTRL,    1'b0, 32'h0000_0002, 1'b0, '0},        // SPSEL, R13 reload
    '{KIND_RD_ACT_SP,  1'b0, 32'h0000_0000, 1'b0, '0},
    '{KIND_WR_ACT_SP,  1'b0, 32'h2FFF_FFF0, 1'b0, '0},
    '{KIND_RD_ACT_LIM, 1'b0, 32'h0000_0000, 1'b0, '0},
    '{KIND_WR_PSP,     1'b0, 32'h2FFF_0000, 1'b0, '0},        // R13 follows
    '{KIND_SET_UNPRIV, 1'b1, 32'h0000_0001, 1'b0, '0},        // bank is ignored
    '{KIND_WR_CTRL,    1'b0, 32'h0000_0000, 1'b0, '0},        // unprivileged thread: kept
    '{KIND_RD_CTRL,    1'b0, 32'h0000_0000, 1'b0, '0},
    '{KIND_SET_MODE,   1'b0, 32'hFFFF_FFFF, 1'b0, '0},        // handler, R13 stays
    '{KIND_WR_ACT_SP,  1'b0, 32'h0800_0000, 1'b0, '0},
    '{KIND_WR_CTRL,    1'b0, 32'h0000_0000, 1'b0, '0},        // handler: write lands
    '{KIND_SET_SEC,    1'b1, 32'h0000_0000, 1'b0, '0},
    '{KIND_WR_VTOR,    1'b1, 32'hFFFF_FFFF, 1'b0, '0},
    '{KIND_RD_VTOR,    1'b1, 32'h0000_0000, 1'b0, '0},
    '{KIND_SET_MODE,   1'b1, 32'hFFFF_FFFE, 1'b0, '0},
    '{KIND_RD_MSP,     1'b1, 32'h0000_0000, 1'b0, '0},
    '{KIND_SET_UNPRIV, 1'b0, 32'h0000_0000, 1'b0, '0}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DataW-1:0]     s_axis_tdata = '0;    // value[31:0]
  logic [InUserW-1:0]   s_axis_tuser = '0;    // kind[3:0], bank[4]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;         // read_data, sp_mirror, privileged, handler_mode,
                                              // nonsecure_now, stack_low_mark, low_mark_valid
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [DataW-1:0]     cfg_wdata_i = '0;

  banked_stack_pointer_regs DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted register file, index 0 secure, 1 non-secure.
  logic [DataW-1:0] lim_main [2] = '{default: '0};
  logic [DataW-1:0] lim_proc [2] = '{default: '0};
  logic [DataW-1:0] msp [2] = '{default: '0};
  logic [DataW-1:0] psp [2] = '{default: '0};
  logic [DataW-1:0] ctrl [2] = '{default: '0};
  logic [DataW-1:0] vtor [2] = '{default: '0};
  logic             unpriv [2] = '{default: 1'b0};
  logic [DataW-1:0] top_mark [2] = '{default: '0};
  logic [DataW-1:0] low_mark [2] = '{default: '0};
  logic             top_known [2] = '{default: 1'b0};
  logic             handler = 1'b0;
  logic             nonsec = 1'b0;
  logic [DataW-1:0] r13 = '0;

  access_t    stim_q [$];
  sp_result_t result_q [$];
  int         mismatches = 0;
  int         idle_cycles = 0;
  logic [DataW-1:0] sp_walk = 32'h2000_8000;

  function automatic void note_top(logic b, logic [DataW-1:0] v);
    if (!top_known[b] && v != '0) begin
      top_mark[b] = v;
      low_mark[b] = v;
      top_known[b] = 1'b1;
    end
  endfunction

  function automatic void lower_mark(logic b, logic [DataW-1:0] v);
    if (top_known[b] && v < low_mark[b]) low_mark[b] = v;
  endfunction

  function automatic sp_result_t exec_access(kind_e k, logic b, logic [DataW-1:0] v);
    sp_result_t r;
    logic cb;
    logic on_psp;
    logic [DataW-1:0] wv;
    r = '0;
    wv = v;
    cb = nonsec;
    on_psp = !handler && ctrl[cb][SpselBit];
    case (k)
      KIND_RD_ACT_SP:  r.rd = on_psp ? psp[cb] : msp[cb];
      KIND_WR_ACT_SP: begin
        if (on_psp) begin
          psp[cb] = v;
        end else begin
          msp[cb] = v;
          note_top(cb, v);
          lower_mark(cb, v);
        end
        r13 = v;
      end
      KIND_RD_ACT_LIM: r.rd = on_psp ? lim_proc[cb] : lim_main[cb];
      KIND_RD_MSP:     r.rd = msp[b];
      KIND_WR_MSP: begin
        msp[b] = v;
        if (b == cb && !on_psp) r13 = v;
        if (b == 1'b0) note_top(b, v);  // top noted on the secure bank only
        lower_mark(b, v);
      end
      KIND_RD_PSP:     r.rd = psp[b];
      KIND_WR_PSP: begin
        psp[b] = v;
        if (b == cb && on_psp) r13 = v;
      end
      KIND_RD_CTRL:    r.rd = ctrl[b];
      KIND_WR_CTRL: begin
        if (b == cb && !handler && ctrl[b][NprivBit]) wv = ctrl[b];
        ctrl[b] = wv;
        unpriv[b] = wv[NprivBit];
        if (b == cb) r13 = (!handler && ctrl[b][SpselBit]) ? psp[b] : msp[b];
      end
      KIND_RD_VTOR:    r.rd = vtor[b];
      KIND_WR_VTOR:    vtor[b] = v;
      KIND_SET_MODE:   handler = v[0];
      KIND_SET_SEC:    nonsec = b;
      KIND_SET_UNPRIV: begin
        unpriv[cb] = v[0];
        ctrl[cb][NprivBit] = v[0];
      end
      KIND_NOTE_TOP:   note_top(b, msp[b]);
      default: ;
    endcase
    r.sp = r13;
    r.priv = handler || !unpriv[nonsec];
    r.hand = handler;
    r.ns = nonsec;
    r.low = low_mark[b];
    r.valid = top_known[b];
    return r;
  endfunction

  function automatic access_t rand_access();
    access_t a;
    a = '0;
    a.kind = kind_e'($urandom_range(0, 15));
    a.bank = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: a.value = '0;
      1: a.value = '1;
      2: a.value = $urandom_range(0, 3);
      3, 4: begin
        // slowly falling stack values drive the low-water marks
        a.value = sp_walk - $urandom_range(0, 4096);
        sp_walk = sp_walk - $urandom_range(0, 64);
      end
      default: a.value = $urandom();
    endcase
    return a;
  endfunction

  task automatic cmp_field(string name, logic [DataW-1:0] want, logic [DataW-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("%0t %s: expected %h, got %h", $realtime, name, want, got);
    end
  endtask

  task automatic check_result(logic [OutDataW-1:0] d);
    sp_result_t want;
    if (result_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("%0t result item with none expected: %h", $realtime, d);
      return;
    end
    want = result_q.pop_front();
    cmp_field("read_data", want.rd, d[OutRdLsb +: DataW]);
    cmp_field("sp_mirror", want.sp, d[OutSpLsb +: DataW]);
    cmp_field("privileged", DataW'(want.priv), DataW'(d[OutPrivBit]));
    cmp_field("handler_mode", DataW'(want.hand), DataW'(d[OutHandBit]));
    cmp_field("nonsecure_now", DataW'(want.ns), DataW'(d[OutNsBit]));
    cmp_field("stack_low_mark", want.low, d[OutLowLsb +: DataW]);
    cmp_field("low_mark_valid", DataW'(want.valid), DataW'(d[OutValidBit]));
  endtask

  // Sender: bursts of random length with random gaps.
  int         gap_left = 0;
  int         burst_left = 1;
  logic       tx_hold;
  access_t    tx_item;
  sp_result_t tx_pred;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      tx_hold = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        tx_item = stim_q.pop_front();
        tx_pred = exec_access(tx_item.kind, tx_item.bank, tx_item.value);
        result_q.push_back(tx_item.fixed ? tx_item.want : tx_pred);
        tx_hold = 1'b0;
      end
      if (!tx_hold) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (stim_q.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= stim_q[0].value;
          s_axis_tuser <= {stim_q[0].bank, stim_q[0].kind};
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern switches every so often.
  int rx_tick = 0;
  int rx_mode = 0;
  int rx_stall = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      rx_tick++;
      if (rx_tick % 97 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= (rx_tick % 3) != 0;
        2: m_axis_tready <= 1'($urandom_range(0, 1));
        default: begin
          if (rx_stall != 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
          end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 7) == 0) rx_stall = $urandom_range(1, 16);
          end
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_cfg(cfg_idx_e idx, logic [DataW-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    case (idx)
      CFG_MAIN_LIM_NS: lim_main[1] = v;
      CFG_MAIN_LIM_S:  lim_main[0] = v;
      CFG_PROC_LIM_NS: lim_proc[1] = v;
      default:         lim_proc[0] = v;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (stim_q.size() != 0 || s_axis_tvalid || result_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_cfg(CFG_MAIN_LIM_NS, 32'h0000_0000);
    write_cfg(CFG_MAIN_LIM_S,  32'hFFFF_FFFF);
    write_cfg(CFG_PROC_LIM_NS, 32'hFFFF_FFFF);
    write_cfg(CFG_PROC_LIM_S,  32'h0000_0000);

    for (int i = 0; i < NDIR; i++) stim_q.push_back(DIR_TAB[i]);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        write_cfg(CFG_MAIN_LIM_NS, 32'hFFFF_FFFF);
        write_cfg(CFG_MAIN_LIM_S,  32'h0000_0000);
        write_cfg(CFG_PROC_LIM_NS, 32'h0000_0000);
        write_cfg(CFG_PROC_LIM_S,  32'hFFFF_FFFF);
      end else begin
        write_cfg(CFG_MAIN_LIM_NS, $urandom());
        write_cfg(CFG_MAIN_LIM_S,  $urandom());
        write_cfg(CFG_PROC_LIM_NS, $urandom());
        write_cfg(CFG_PROC_LIM_S,  $urandom());
      end
      for (int n = 0; n < RAND_PER_PHASE; n++) stim_q.push_back(rand_access());
      drain();
    end

    // catch any stray result items
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
